@@ rtl/ansi_stripping_line_assembler_defines.svh @@
// Assertion macros shared by the line assembler modules.
`ifndef ANSI_STRIPPING_LINE_ASSEMBLER_DEFINES_SVH
`define ANSI_STRIPPING_LINE_ASSEMBLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASLB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/aslb_pkg.sv @@
// Shared constants, types and helper functions of the line assembler.
package aslb_pkg;

  localparam logic [7:0] CODE_ESC     = 8'd27;
  localparam logic [7:0] CODE_LF      = 8'd10;
  localparam logic [7:0] CODE_CR      = 8'd13;
  localparam logic [7:0] CODE_BRACKET = 8'd91;
  localparam logic [7:0] CODE_ZERO    = 8'd48;
  localparam logic [7:0] PRINT_LO     = 8'd32;
  localparam logic [7:0] PRINT_HI     = 8'd126;
  localparam logic [7:0] FINAL_LO     = 8'h40;
  localparam logic [7:0] FINAL_HI     = 8'h7E;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_ABORT = 2'd2;

  // Four line banks: one being filled, up to three owned by the back end.
  localparam int BANK_W    = 2;
  localparam int NUM_BANKS = 1 << BANK_W;

  localparam int              SILENCE_W     = 16;
  localparam logic [15:0]     SILENCE_RESET = 16'd500;

  localparam int   REG_IDX_W   = 1;
  localparam logic REG_SILENCE = 1'b0;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } result_t;

  function automatic logic is_printable(input logic [7:0] v);
    return (v >= PRINT_LO) && (v <= PRINT_HI);
  endfunction

  function automatic logic is_final(input logic [7:0] v);
    return (v >= FINAL_LO) && (v <= FINAL_HI);
  endfunction

endpackage

@@ rtl/aslb_cmd_fifo.sv @@
// Two-entry command queue between the line collector and the message walker.
`include "ansi_stripping_line_assembler_defines.svh"

module aslb_cmd_fifo #(
  parameter int W = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  `ASLB_ASSERT_NOW(a_no_push_full, push, !full, "command pushed into a full queue")
  `ASLB_ASSERT_NOW(a_no_pop_empty, pop, !empty, "command popped from an empty queue")
  `ASLB_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 2'd1,
                    "queue count did not grow on push")

endmodule

@@ rtl/aslb_front.sv @@
// Front end: classifies incoming requests, fills the line banks, decides finalizing.
module aslb_front #(
  parameter int  LINE_DEPTH = 128,
  localparam int IW         = $clog2(LINE_DEPTH),
  localparam int CMD_W      = aslb_pkg::BANK_W + IW + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                stall,
  input  logic [1:0]                          func,
  input  logic [7:0]                          byte_value,
  input  logic [aslb_pkg::SILENCE_W-1:0]      silence_limit,
  output logic                                cmd_push,
  output logic [CMD_W-1:0]                    cmd_data,
  output logic                                wr_en,
  output logic [aslb_pkg::BANK_W+IW-1:0]      wr_addr,
  output logic [7:0]                          wr_data
);
  import aslb_pkg::*;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [IW-1:0]     len;
    logic              esc_line;
  } cmd_t;

  logic [IW-1:0]        fill, fill_next;
  logic [SILENCE_W-1:0] silence, silence_next;
  logic [BANK_W-1:0]    bank, bank_next;
  logic                 esc_line, esc_line_next;
  logic                 b1_bracket, b1_bracket_next;
  logic                 b2_zero, b2_zero_next;

  logic                 accept;
  logic                 byte_ok;
  logic                 finalize;
  logic [IW-1:0]        fin_len;
  logic [SILENCE_W:0]   silence_inc;
  cmd_t                 cmd;

  assign accept  = push && !stall;
  assign byte_ok = is_printable(byte_value) || (byte_value == CODE_ESC) ||
                   (byte_value == CODE_LF) || (byte_value == CODE_CR);
  assign silence_inc = {1'b0, silence} + {{SILENCE_W{1'b0}}, 1'b1};

  always_comb begin
    fill_next       = fill;
    silence_next    = silence;
    bank_next       = bank;
    esc_line_next   = esc_line;
    b1_bracket_next = b1_bracket;
    b2_zero_next    = b2_zero;
    wr_en           = 1'b0;
    finalize        = 1'b0;
    fin_len         = fill;
    if (accept) begin
      case (func)
        FUNC_BYTE: begin
          if (!byte_ok) begin
            // Unsupported byte: dropped, silence keeps counting.
          end else if ((fill == '0) && (byte_value != CODE_ESC) &&
                       !is_printable(byte_value)) begin
            // A line cannot open with CR or LF.
          end else if ((fill == IW'(1)) && esc_line && (byte_value != CODE_BRACKET)) begin
            fill_next    = '0;
            silence_next = '0;
          end else if (fill >= IW'(LINE_DEPTH - 1)) begin
            fill_next    = '0;
            silence_next = '0;
          end else begin
            wr_en        = 1'b1;
            fill_next    = fill + IW'(1);
            silence_next = '0;
            if (fill == '0) begin
              esc_line_next = (byte_value == CODE_ESC);
            end
            if (fill == IW'(1)) begin
              b1_bracket_next = (byte_value == CODE_BRACKET);
            end
            if (fill == IW'(2)) begin
              b2_zero_next = (byte_value == CODE_ZERO);
            end
            if (byte_value == CODE_LF) begin
              // An ESC line only ends on LF when it opens with ESC '[' '0'.
              if (!esc_line || ((fill >= IW'(3)) && b1_bracket && b2_zero)) begin
                finalize = 1'b1;
                fin_len  = fill + IW'(1);
              end
            end
          end
        end
        FUNC_TICK: begin
          if (fill != '0) begin
            if (silence_inc > {1'b0, silence_limit}) begin
              finalize = 1'b1;
              fin_len  = fill;
            end else begin
              silence_next = silence_inc[SILENCE_W-1:0];
            end
          end
        end
        FUNC_ABORT: begin
          fill_next    = '0;
          silence_next = '0;
        end
        default: begin
        end
      endcase
    end
    if (finalize) begin
      fill_next    = '0;
      silence_next = '0;
      bank_next    = bank + BANK_W'(1);
    end
  end

  always_comb begin
    cmd.bank     = bank;
    cmd.len      = fin_len;
    cmd.esc_line = esc_line;
  end

  assign cmd_push = finalize;
  assign cmd_data = cmd;
  assign wr_addr  = {bank, fill};
  assign wr_data  = byte_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      silence    <= '0;
      bank       <= '0;
      esc_line   <= 1'b0;
      b1_bracket <= 1'b0;
      b2_zero    <= 1'b0;
    end else begin
      fill       <= fill_next;
      silence    <= silence_next;
      bank       <= bank_next;
      esc_line   <= esc_line_next;
      b1_bracket <= b1_bracket_next;
      b2_zero    <= b2_zero_next;
    end
  end

endmodule

@@ rtl/aslb_back.sv @@
// Back end: line memory and the walker that strips CSI sequences and emits characters.
`include "ansi_stripping_line_assembler_defines.svh"

module aslb_back #(
  parameter int  LINE_DEPTH = 128,
  parameter int  MSG_MAX    = 64,
  localparam int IW         = $clog2(LINE_DEPTH),
  localparam int CMD_W      = aslb_pkg::BANK_W + IW + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  logic [CMD_W-1:0]               cmd_data,
  output logic                           cmd_pop,
  input  logic                           wr_en,
  input  logic [aslb_pkg::BANK_W+IW-1:0] wr_addr,
  input  logic [7:0]                     wr_data,
  input  logic                           pop,
  output logic                           empty,
  output aslb_pkg::result_t              result
);
  import aslb_pkg::*;

  localparam int KW        = $clog2(MSG_MAX + 1);
  localparam int MEM_DEPTH = NUM_BANKS * (1 << IW);

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [IW-1:0]     len;
    logic              esc_line;
  } cmd_t;

  typedef enum logic [1:0] {B_IDLE, B_READ, B_PROC, B_FLUSH} state_t;
  typedef enum logic [1:0] {M_NORMAL, M_AFTER_ESC, M_CSI} mode_t;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rd_data;

  state_t            state, state_next;
  mode_t             mode, mode_next;
  logic [BANK_W-1:0] bank, bank_next;
  logic [IW-1:0]     len, len_next;
  logic              esc_line, esc_line_next;
  logic [IW-1:0]     idx, idx_next;
  logic [KW-1:0]     kept, kept_next;
  logic              pend_valid, pend_valid_next;
  logic [6:0]        pend_char, pend_char_next;
  logic              out_valid, out_valid_next;
  result_t           out_res, out_res_next;

  cmd_t              cmd;
  logic              out_free;
  logic              advance;
  logic [IW:0]       idx_inc;
  logic [KW-1:0]     kept_inc;

  assign cmd      = cmd_t'(cmd_data);
  assign out_free = !out_valid || pop;
  assign idx_inc  = {1'b0, idx} + {{IW{1'b0}}, 1'b1};
  assign kept_inc = kept + KW'(1);
  assign empty    = !out_valid;
  assign result   = out_res;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[{bank, idx}];
  end

  always_comb begin
    state_next      = state;
    mode_next       = mode;
    bank_next       = bank;
    len_next        = len;
    esc_line_next   = esc_line;
    idx_next        = idx;
    kept_next       = kept;
    pend_valid_next = pend_valid;
    pend_char_next  = pend_char;
    out_valid_next  = out_valid && !pop;
    out_res_next    = out_res;
    cmd_pop         = 1'b0;
    advance         = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop         = 1'b1;
          bank_next       = cmd.bank;
          len_next        = cmd.len;
          esc_line_next   = cmd.esc_line;
          idx_next        = '0;
          kept_next       = '0;
          pend_valid_next = 1'b0;
          mode_next       = M_NORMAL;
          state_next      = B_READ;
        end
      end
      B_READ: begin
        state_next = B_PROC;
      end
      B_PROC: begin
        if (mode == M_CSI) begin
          if (is_final(rd_data)) begin
            mode_next = M_NORMAL;
          end
          advance = 1'b1;
        end else if ((mode == M_AFTER_ESC) && (rd_data == CODE_BRACKET)) begin
          mode_next = M_CSI;
          advance   = 1'b1;
        end else begin
          // A lone ESC is dropped and the byte after it is taken as ordinary text.
          mode_next = M_NORMAL;
          if (esc_line && (rd_data == CODE_ESC)) begin
            mode_next = M_AFTER_ESC;
            advance   = 1'b1;
          end else if ((rd_data == CODE_CR) || (rd_data == CODE_LF)) begin
            state_next = B_FLUSH;
          end else if (is_printable(rd_data)) begin
            // The held character goes out only once we know it is not the last.
            if (!pend_valid || out_free) begin
              if (pend_valid) begin
                out_valid_next         = 1'b1;
                out_res_next.char_code = pend_char;
                out_res_next.last      = 1'b0;
              end
              pend_valid_next = 1'b1;
              pend_char_next  = rd_data[6:0];
              kept_next       = kept_inc;
              if (kept_inc == KW'(MSG_MAX)) begin
                state_next = B_FLUSH;
              end else begin
                advance = 1'b1;
              end
            end
          end else begin
            advance = 1'b1;
          end
        end
      end
      B_FLUSH: begin
        if (!pend_valid) begin
          state_next = B_IDLE;
        end else if (out_free) begin
          out_valid_next         = 1'b1;
          out_res_next.char_code = pend_char;
          out_res_next.last      = 1'b1;
          pend_valid_next        = 1'b0;
          state_next             = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
    if (advance) begin
      if (idx_inc == {1'b0, len}) begin
        state_next = B_FLUSH;
      end else begin
        idx_next   = idx_inc[IW-1:0];
        state_next = B_READ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      mode       <= M_NORMAL;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      kept       <= '0;
      bank       <= '0;
      len        <= '0;
      esc_line   <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      idx        <= idx_next;
      kept       <= kept_next;
      bank       <= bank_next;
      len        <= len_next;
      esc_line   <= esc_line_next;
    end
    pend_char <= pend_char_next;
    out_res   <= out_res_next;
  end

  `ASLB_ASSERT_NOW(a_kept_below_max, state == B_PROC, kept < KW'(MSG_MAX),
                   "walker still running with a full message")
  `ASLB_ASSERT_NOW(a_idx_in_line, (state == B_READ) || (state == B_PROC), idx < len,
                   "walker index ran past the line length")
  `ASLB_ASSERT_NOW(a_pop_when_idle, cmd_pop, state == B_IDLE,
                   "command taken while a line is being walked")
  `ASLB_ASSERT_NEXT(a_start_walk, cmd_pop, (state == B_READ) && (idx == '0),
                    "walk did not start at the head of the line")

endmodule

@@ rtl/ansi_stripping_line_assembler.sv @@
// Top level of the ANSI-stripping line assembler: register port and front/back wiring.
//
// Channel   | Handshake              | Payload
// ----------+------------------------+---------------------------------
// input     | push / full            | func, byte_value
// result    | pop / empty            | char_code, last
// config    | APB psel/penable/pready| paddr, pwdata, prdata
//
// The front end takes one request per cycle whenever full is low. A finalized
// line is walked by the back end one stored byte at a time (one registered
// memory read, then one classification step), and the walk also waits on pop
// while the result register is still occupied.
// Two finalized lines can wait in the command queue; full rises only while both
// slots are taken. Reset is synchronous and clears counters and queues; the line
// memory is not cleared and needs no clearing pass.
module ansi_stripping_line_assembler #(
  parameter int LINE_DEPTH = 128,
  parameter int MSG_MAX    = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input queue
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            func,
  input  logic [7:0]                            byte_value,
  // result queue
  input  logic                                  pop,
  output logic                                  empty,
  output logic [6:0]                            char_code,
  output logic                                  last,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [aslb_pkg::REG_IDX_W+1:0]        paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import aslb_pkg::*;

  localparam int IW    = $clog2(LINE_DEPTH);
  localparam int CMD_W = BANK_W + IW + 1;

  logic [SILENCE_W-1:0]  silence_limit;
  logic                  reg_hit;

  logic                  cmd_push;
  logic [CMD_W-1:0]      cmd_wdata;
  logic                  cmd_full;
  logic                  cmd_pop;
  logic [CMD_W-1:0]      cmd_rdata;
  logic                  cmd_empty;

  logic                  wr_en;
  logic [BANK_W+IW-1:0]  wr_addr;
  logic [7:0]            wr_data;

  result_t               result;

  // Register index sits above the byte offset within a 32-bit word.
  assign reg_hit = (paddr[REG_IDX_W+1:2] == REG_SILENCE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_limit <= SILENCE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      silence_limit <= pwdata[SILENCE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = 32'(silence_limit);
    end
  end

  // New requests are held off only while the command queue cannot take a
  // finalized line; this also keeps the bank being filled out of the walker's way.
  assign full = cmd_full;

  aslb_front #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .stall         (cmd_full),
    .func          (func),
    .byte_value    (byte_value),
    .silence_limit (silence_limit),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_wdata),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  aslb_cmd_fifo #(
    .W (CMD_W)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  aslb_back #(
    .LINE_DEPTH (LINE_DEPTH),
    .MSG_MAX    (MSG_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign char_code = result.char_code;
  assign last      = result.last;

endmodule

@@ test/ansi_stripping_line_assembler_tb.sv @@
// Self-checking testbench for the ANSI-stripping line assembler.
module ansi_stripping_line_assembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aslb_pkg::*;

  localparam int LINE_DEPTH = 128;
  localparam int MSG_MAX    = 64;

  // The back end walks a line one byte at a time; up to three lines can be
  // in flight, so this many quiet cycles guarantees the block has gone idle.
  localparam int DRAIN_CYCLES   = 1000;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int PHASE_REQUESTS = 8;

  // Function code that the block defines no behavior for.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       push = 1'b0;
  logic       full;
  logic [1:0] func = FUNC_BYTE;
  logic [7:0] byte_value = 8'd0;

  logic       pop = 1'b0;
  logic       empty;
  logic [6:0] char_code;
  logic       last;

  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [REG_IDX_W+1:0]   paddr = '0;
  logic [31:0]            pwdata = 32'd0;
  logic [31:0]            prdata;
  logic                   pready;

  ansi_stripping_line_assembler #(
    .LINE_DEPTH(LINE_DEPTH),
    .MSG_MAX(MSG_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .func(func),
    .byte_value(byte_value),
    .pop(pop),
    .empty(empty),
    .char_code(char_code),
    .last(last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block: the line being collected, the silence counter
  // and the configured silence limit.
  logic [7:0]  line_mem [LINE_DEPTH];
  int unsigned line_fill;
  logic [15:0] quiet_ticks;
  logic [15:0] silence_cfg;

  // Characters produced by the most recent request, and the characters that
  // the block still owes us, oldest first.
  result_t msg_out[$];
  result_t char_queue[$];
  result_t want;

  int  mismatches = 0;
  int  chars_checked = 0;
  int  requests_sent = 0;
  int  reg_writes = 0;
  int  cycles = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  function automatic bit glyph_byte(logic [7:0] v);
    return v >= PRINT_LO && v <= PRINT_HI;
  endfunction

  function automatic bit csi_final(logic [7:0] v);
    return v >= FINAL_LO && v <= FINAL_HI;
  endfunction

  function automatic void drop_line();
    line_fill = 0;
    quiet_ticks = 16'd0;
  endfunction

  // Walk the stored line and produce the message characters. On a line that
  // opens with ESC, every ESC '[' ... final-byte run is removed; a lone ESC is
  // skipped. CR or LF ends the message, other control bytes are skipped.
  function automatic void extract_message();
    bit          esc_line;
    int unsigned i;
    int unsigned n;
    result_t     r;
    esc_line = (line_mem[0] == CODE_ESC);
    i = 0;
    n = 0;
    while (i < line_fill && n < MSG_MAX) begin
      if (esc_line && line_mem[i] == CODE_ESC) begin
        if (i + 1 >= line_fill || line_mem[i + 1] != CODE_BRACKET) begin
          i++;
        end else begin
          i += 2;
          while (i < line_fill && !csi_final(line_mem[i])) i++;
          if (i < line_fill) i++;
        end
      end else if (line_mem[i] == CODE_CR || line_mem[i] == CODE_LF) begin
        break;
      end else begin
        if (glyph_byte(line_mem[i])) begin
          r.char_code = line_mem[i][6:0];
          r.last = 1'b0;
          msg_out.push_back(r);
          n++;
        end
        i++;
      end
    end
    if (n > 0) msg_out[n - 1].last = 1'b1;
    drop_line();
  endfunction

  // Advance the shadow copy by one request; its characters land in msg_out.
  function automatic void predict_request(logic [1:0] f, logic [7:0] b);
    logic [16:0] next_quiet;
    msg_out.delete();
    case (f)
      FUNC_BYTE: begin
        if (!(glyph_byte(b) || b == CODE_ESC || b == CODE_LF || b == CODE_CR)) begin
          // Bytes outside the accepted set leave the line untouched.
        end else if (line_fill == 0 && b != CODE_ESC && !glyph_byte(b)) begin
          // A line cannot open with CR or LF.
        end else if (line_fill == 1 && line_mem[0] == CODE_ESC && b != CODE_BRACKET) begin
          drop_line();
        end else if (line_fill >= LINE_DEPTH - 1) begin
          drop_line();
        end else begin
          line_mem[line_fill] = b;
          line_fill++;
          quiet_ticks = 16'd0;
          if (b == CODE_LF) begin
            if (line_mem[0] != CODE_ESC) begin
              extract_message();
            end else if (line_fill >= 3 && line_mem[1] == CODE_BRACKET &&
                         line_mem[2] == CODE_ZERO) begin
              extract_message();
            end
          end
        end
      end
      FUNC_TICK: begin
        if (line_fill != 0) begin
          next_quiet = {1'b0, quiet_ticks} + 17'd1;
          if (next_quiet > {1'b0, silence_cfg}) extract_message();
          else quiet_ticks = next_quiet[15:0];
        end
      end
      FUNC_ABORT: drop_line();
      default: ;
    endcase
  endfunction

  // Directed stimulus. Rows marked typed carry their expectation by hand
  // (at most one character); the rest are checked through the shadow copy.
  typedef struct packed {
    logic [1:0] func_code;
    logic [7:0] value;
    logic       typed;
    logic       one_char;
    logic [6:0] char_val;
    logic       char_last;
  } step_row_t;

  localparam int SCRIPT_ROWS = 25;
  localparam step_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{FUNC_UNUSED, 8'hFF,        1'b1, 1'b0, 7'h00, 1'b0}, // undefined code
    '{FUNC_TICK,   8'h00,        1'b1, 1'b0, 7'h00, 1'b0}, // tick, nothing pending
    '{FUNC_ABORT,  8'hA5,        1'b1, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   CODE_LF,      1'b1, 1'b0, 7'h00, 1'b0}, // LF cannot open a line
    '{FUNC_BYTE,   8'h00,        1'b1, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   8'hFF,        1'b1, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   8'h41,        1'b1, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   CODE_LF,      1'b1, 1'b1, 7'h41, 1'b1}, // "A" comes out alone
    '{FUNC_BYTE,   PRINT_HI,     1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   PRINT_LO,     1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   8'h7F,        1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   8'h1F,        1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   CODE_CR,      1'b0, 1'b0, 7'h00, 1'b0}, // message stops here
    '{FUNC_BYTE,   8'h5A,        1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   CODE_LF,      1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   CODE_ESC,     1'b0, 1'b0, 7'h00, 1'b0}, // ESC [ 0 m H LF
    '{FUNC_BYTE,   CODE_BRACKET, 1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   CODE_ZERO,    1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   8'h6D,        1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   8'h48,        1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   CODE_LF,      1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   CODE_ESC,     1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_BYTE,   8'h78,        1'b1, 1'b0, 7'h00, 1'b0}, // ESC without '[' drops it
    '{FUNC_BYTE,   8'h71,        1'b0, 1'b0, 7'h00, 1'b0},
    '{FUNC_ABORT,  8'h00,        1'b1, 1'b0, 7'h00, 1'b0}  // rejected packet
  };

  // Present one request and hold it until the block takes it. Inputs are driven
  // with nonblocking assignments, and the request is held while full is high.
  task automatic send_item(input logic [1:0] f, input logic [7:0] b,
                           input bit use_model = 1'b1);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    push <= 1'b1;
    func <= f;
    byte_value <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_request(f, b);
    if (use_model) begin
      foreach (msg_out[k]) char_queue.push_back(msg_out[k]);
    end
    if (f != FUNC_UNUSED) requests_sent++;
  endtask

  // Stop sending, let every owed character arrive, then give the back end
  // time to finish lines that produce no characters at all.
  task automatic settle();
    push <= 1'b0;
    while (char_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input bit wr, input logic [REG_IDX_W+1:0] addr,
                            input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!wr && prdata !== 32'(silence_cfg)) begin
      $display("%0t: silence_limit read expected %0d actual %0d",
               $time, silence_cfg, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      reg_writes++;
      if (addr[REG_IDX_W+1:2] == REG_SILENCE) silence_cfg = data[15:0];
    end
  endtask

  task automatic set_silence(input logic [15:0] limit);
    apb_access(1'b1, {REG_SILENCE, 2'b00}, 32'(limit));
    apb_access(1'b0, {REG_SILENCE, 2'b00}, 32'd0);
  endtask

  // Mostly printable text, with the occasional CR, ESC, '[', CSI final byte
  // or arbitrary byte mixed in.
  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0: return CODE_CR;
      1: return CODE_ESC;
      2: return CODE_BRACKET;
      3: return 8'($urandom_range(0, 255));
      4: return 8'($urandom_range(FINAL_LO, FINAL_HI));
      default: return 8'($urandom_range(PRINT_LO, PRINT_HI));
    endcase
  endfunction

  task automatic send_csi();
    send_item(FUNC_BYTE, CODE_ESC);
    send_item(FUNC_BYTE, CODE_BRACKET);
    repeat ($urandom_range(0, 3)) send_item(FUNC_BYTE, 8'($urandom_range(8'h30, 8'h3F)));
    if ($urandom_range(0, 5) != 0)
      send_item(FUNC_BYTE, 8'($urandom_range(FINAL_LO, FINAL_HI)));
  endtask

  // Close a line: mostly LF, sometimes silence, an abort, or left open.
  task automatic close_line();
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k < 13) begin
      send_item(FUNC_BYTE, CODE_LF);
    end else if (k < 17) begin
      repeat ($urandom_range(1, (silence_cfg < 16) ? silence_cfg + 2 : 8))
        send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
    end else if (k < 19) begin
      send_item(FUNC_ABORT, 8'($urandom_range(0, 255)));
    end
  endtask

  // One random sequence: a plain line, an ESC line with CSI runs, a burst of
  // noise, or a broken ESC opening.
  task automatic send_line();
    int unsigned kind;
    kind = $urandom_range(0, 19);
    if (kind < 8) begin
      send_item(FUNC_BYTE, 8'($urandom_range(PRINT_LO, PRINT_HI)));
      repeat ($urandom_range(0, 20)) send_item(FUNC_BYTE, pick_text_byte());
      close_line();
    end else if (kind < 15) begin
      send_item(FUNC_BYTE, CODE_ESC);
      send_item(FUNC_BYTE, CODE_BRACKET);
      send_item(FUNC_BYTE, ($urandom_range(0, 4) != 0) ?
                CODE_ZERO : 8'($urandom_range(PRINT_LO, PRINT_HI)));
      repeat ($urandom_range(0, 2)) send_item(FUNC_BYTE, 8'($urandom_range(8'h30, 8'h3F)));
      send_item(FUNC_BYTE, 8'($urandom_range(FINAL_LO, FINAL_HI)));
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 2) == 0) send_csi();
        repeat ($urandom_range(0, 6)) send_item(FUNC_BYTE, pick_text_byte());
      end
      close_line();
    end else if (kind < 18) begin
      repeat ($urandom_range(1, 6))
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end else begin
      send_item(FUNC_BYTE, CODE_ESC);
      if ($urandom_range(0, 1) == 0) send_item(FUNC_BYTE, pick_text_byte());
      else close_line();
    end
  endtask

  // Result side: compare every accepted character with the oldest one owed,
  // and pull pop low in random bursts unless the run is in its calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (char_queue.size() == 0) begin
          $display("%0t: unexpected character expected none actual %0d last %0b",
                   $time, char_code, last);
          mismatches++;
        end else begin
          want = char_queue.pop_front();
          if (char_code !== want.char_code) begin
            $display("%0t: char_code expected %0d actual %0d",
                     $time, want.char_code, char_code);
            mismatches++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            mismatches++;
          end
          chars_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    line_fill = 0;
    quiet_ticks = 16'd0;
    silence_cfg = SILENCE_RESET;
    for (int i = 0; i < LINE_DEPTH; i++) line_mem[i] = 8'd0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // After reset the register must read back its default.
    apb_access(1'b0, {REG_SILENCE, 2'b00}, 32'd0);
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      send_item(SCRIPT[i].func_code, SCRIPT[i].value, !SCRIPT[i].typed);
      if (SCRIPT[i].typed && SCRIPT[i].one_char)
        char_queue.push_back('{char_code: SCRIPT[i].char_val, last: SCRIPT[i].char_last});
    end
    settle();

    // Shortest silence: a line closes on the second quiet tick.
    set_silence(16'd1);
    while (requests_sent < SCRIPT_ROWS + PHASE_REQUESTS) send_line();
    settle();

    // A short random limit, plus one line longer than MSG_MAX.
    set_silence(16'($urandom_range(2, 12)));
    repeat (MSG_MAX + 1) send_item(FUNC_BYTE, 8'($urandom_range(PRINT_LO, PRINT_HI)));
    send_item(FUNC_BYTE, CODE_LF);
    begin : mid_phase
      int goal;
      goal = requests_sent + PHASE_REQUESTS;
      while (requests_sent < goal) send_line();
    end
    settle();

    // Longest silence: a few quiet ticks must leave the pending line open,
    // and LF then closes it. A write to the unused index must change nothing.
    set_silence(16'hFFFF);
    apb_access(1'b1, {~REG_SILENCE, 2'b00}, 32'd7);
    apb_access(1'b0, {REG_SILENCE, 2'b00}, 32'd0);
    send_item(FUNC_BYTE, 8'h58);
    repeat (4) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
    send_item(FUNC_BYTE, CODE_LF);
    settle();

    // Closing stretch with both sides running flat out.
    calm = 1'b1;
    set_silence(16'($urandom_range(1, 6)));
    begin : last_phase
      int goal;
      goal = requests_sent + PHASE_REQUESTS;
      while (requests_sent < goal) send_line();
    end
    settle();

    $display("Checked %0d characters from %0d requests across %0d register writes.",
             chars_checked, requests_sent, reg_writes);
    $display("Silence limits from 1 to 65535, CSI stripping, long messages and aborts exercised.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
